>>> hw/rtl/wsd_pkg.sv
// types and constants shared by the websocket frame deframer
// no dependencies

package wsd_pkg;

  localparam int unsigned LEN_W = 32;
  localparam int unsigned KEY_W = 32;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [2:0] EXT16_LAST = 3'd1;
  localparam logic [2:0] EXT64_LAST = 3'd7;
  localparam logic [2:0] KEY_LAST   = 3'd3;

  localparam logic [3:0] OP_CONT = 4'h0;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_MARKER = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    PH_FLAG  = 3'd0,
    PH_LEN   = 3'd1,
    PH_EXT16 = 3'd2,
    PH_EXT64 = 3'd3,
    PH_KEY   = 3'd4,
    PH_DATA  = 3'd5
  } phase_t;

  typedef struct packed {
    phase_t             phase;
    logic [2:0]         hdr_cnt;
    logic [LEN_W-1:0]   remaining;
    logic [KEY_W-1:0]   mask_key;
    logic               mask_present;
    logic [1:0]         mask_index;
    logic [3:0]         opcode;
    logic               fin;
  } parse_state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] payload_byte;
    logic [3:0] frame_opcode;
    logic       is_control;
    logic       message_first;
    logic       final_frame;
    logic       frame_last;
  } result_t;

endpackage

>>> hw/rtl/wsd_parser.sv
// frame header and payload parser: next state and result for one byte
// depends on wsd_pkg

module wsd_parser (
  input  wsd_pkg::parse_state_t st,
  input  logic [7:0]            rx_byte,
  output wsd_pkg::parse_state_t st_nxt,
  output logic                  res_valid,
  output wsd_pkg::result_t      res
);
  import wsd_pkg::*;

  logic             hdr_done;
  logic             key_taken;
  logic [7:0]       key_byte;
  logic [LEN_W-1:0] rem_dec;
  logic [2:0]       ext_last;

  always_comb begin
    st_nxt    = st;
    res_valid = 1'b0;
    hdr_done  = 1'b0;
    key_taken = 1'b0;
    key_byte  = st.mask_present ? st.mask_key[{st.mask_index, 3'b000} +: 8] : 8'h00;
    rem_dec   = st.remaining - LEN_W'(1);
    ext_last  = (st.phase == PH_EXT16) ? EXT16_LAST : EXT64_LAST;

    res.kind          = KIND_DATA;
    res.payload_byte  = rx_byte ^ key_byte;
    res.frame_opcode  = st.opcode;
    res.is_control    = st.opcode[3];
    res.message_first = (st.opcode != OP_CONT);
    res.final_frame   = st.fin;
    res.frame_last    = 1'b0;

    unique case (st.phase)
      PH_LEN: begin
        st_nxt.mask_present = rx_byte[7];
        if (!rx_byte[7]) begin
          st_nxt.mask_key = '0;
        end
        st_nxt.hdr_cnt   = '0;
        st_nxt.remaining = '0;
        if (rx_byte[6:0] == LEN7_EXT16) begin
          st_nxt.phase = PH_EXT16;
        end else if (rx_byte[6:0] == LEN7_EXT64) begin
          st_nxt.phase = PH_EXT64;
        end else begin
          st_nxt.remaining = {{(LEN_W-7){1'b0}}, rx_byte[6:0]};
          hdr_done         = 1'b1;
        end
      end
      PH_EXT16, PH_EXT64: begin
        st_nxt.remaining = {st.remaining[LEN_W-9:0], rx_byte};
        if (st.hdr_cnt == ext_last) begin
          hdr_done = 1'b1;
        end else begin
          st_nxt.hdr_cnt = st.hdr_cnt + 3'd1;
        end
      end
      PH_KEY: begin
        st_nxt.mask_key[{st.hdr_cnt[1:0], 3'b000} +: 8] = rx_byte;
        if (st.hdr_cnt == KEY_LAST) begin
          hdr_done  = 1'b1;
          key_taken = 1'b1;
        end else begin
          st_nxt.hdr_cnt = st.hdr_cnt + 3'd1;
        end
      end
      PH_DATA: begin
        st_nxt.mask_index = st.mask_index + 2'd1;
        st_nxt.remaining  = rem_dec;
        res_valid         = 1'b1;
        if (rem_dec == '0) begin
          st_nxt.phase   = PH_FLAG;
          res.frame_last = 1'b1;
        end
      end
      default: begin
        st_nxt.opcode  = rx_byte[3:0];
        st_nxt.fin     = rx_byte[7];
        st_nxt.hdr_cnt = '0;
        st_nxt.phase   = PH_LEN;
      end
    endcase

    if (hdr_done) begin
      st_nxt.hdr_cnt    = '0;
      st_nxt.mask_index = '0;
      if (st_nxt.mask_present && !key_taken) begin
        st_nxt.phase = PH_KEY;
      end else if (st_nxt.remaining == '0) begin
        st_nxt.phase     = PH_FLAG;
        res_valid        = 1'b1;
        res.kind         = KIND_MARKER;
        res.payload_byte = 8'h00;
        res.frame_last   = 1'b1;
      end else begin
        st_nxt.phase = PH_DATA;
      end
    end
  end

endmodule

>>> hw/rtl/websocket_frame_deframer.sv
// websocket frame deframer top level: input register, parser, result register
// depends on wsd_pkg and wsd_parser
//
// Takes one received byte per beat and parses websocket frames (flag byte,
// length byte, optional 16- or 64-bit extended length of which the low 32 bits
// are kept, optional 4-byte mask key). Each payload byte leaves unmasked with
// the frame's opcode and flags; an empty frame gives one marker beat. Header
// bytes give no result. A byte is accepted every cycle unless the result register
// is held by out_ready low: it is held in the input register, parsed from there
// and its result lands in the result register. Throughput is one byte
// per cycle, set by the single parse step on the state registers; it drops only
// while the result register is held by out_ready low.

module websocket_frame_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_kind,
  output logic [7:0] out_payload_byte,
  output logic [3:0] out_frame_opcode,
  output logic       out_is_control,
  output logic       out_message_first,
  output logic       out_final_frame,
  output logic       out_frame_last
);
  import wsd_pkg::*;

  logic         in_valid_r;
  logic [7:0]   in_byte_r;
  parse_state_t state_r;
  parse_state_t state_nxt;
  logic         res_valid;
  result_t      res;
  logic         out_valid_r;
  result_t      out_r;
  logic         out_free;
  logic         fire;

  assign out_free = !out_valid_r || out_ready;
  assign fire     = in_valid_r && out_free;
  assign in_ready = !in_valid_r || out_free;

  wsd_parser u_parser (
    .st        (state_r),
    .rx_byte   (in_byte_r),
    .st_nxt    (state_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '{phase: PH_FLAG, default: '0};
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (fire) begin
        state_r <= state_nxt;
      end
      if (out_free) begin
        out_valid_r <= fire && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
    if (out_free && fire && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_r.kind;
  assign out_payload_byte  = out_r.payload_byte;
  assign out_frame_opcode  = out_r.frame_opcode;
  assign out_is_control    = out_r.is_control;
  assign out_message_first = out_r.message_first;
  assign out_final_frame   = out_r.final_frame;
  assign out_frame_last    = out_r.frame_last;

  a_flag_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && state_r.phase == PH_FLAG) |=> !out_valid_r)
    else $error("flag byte produced a result");

  a_marker_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KIND_MARKER) |->
      (out_r.frame_last && out_r.payload_byte == 8'h00))
    else $error("malformed empty-frame marker");

  a_data_remaining: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == PH_DATA) |-> (state_r.remaining != '0))
    else $error("payload phase with no bytes remaining");

  a_unmasked_key: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.phase == PH_DATA && !state_r.mask_present) |-> (state_r.mask_key == '0))
    else $error("unmasked frame kept a stale key");

endmodule

>>> tb/wsd_frame_checker.sv
// beat checker for the websocket frame deframer: predicts results from accepted input beats
// and compares every output beat with the oldest prediction, depends on wsd_pkg
`timescale 1ns / 1ps

module wsd_frame_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       out_kind,
  input  logic [7:0] out_payload_byte,
  input  logic [3:0] out_frame_opcode,
  input  logic       out_is_control,
  input  logic       out_message_first,
  input  logic       out_final_frame,
  input  logic       out_frame_last,
  output int         fail_count,
  output int         pending
);
  import wsd_pkg::*;

  phase_t      ph;
  logic [2:0]  hdr_idx;
  logic [31:0] bytes_left;
  logic [31:0] key;
  logic        masked;
  logic [1:0]  key_pos;
  logic [3:0]  op;
  logic        fin_bit;

  result_t predicted_beats[$];
  result_t got;
  result_t want;

  function automatic result_t make_beat(kind_t k, logic [7:0] data, logic last);
    result_t r;
    r.kind          = k;
    r.payload_byte  = data;
    r.frame_opcode  = op;
    r.is_control    = op[3];
    r.message_first = (op != OP_CONT);
    r.final_frame   = fin_bit;
    r.frame_last    = last;
    return r;
  endfunction

  task automatic finish_header(input bit key_done);
    hdr_idx = '0;
    key_pos = '0;
    if (masked && !key_done) begin
      ph = PH_KEY;
    end else if (bytes_left == 0) begin
      ph = PH_FLAG;
      predicted_beats.push_back(make_beat(KIND_MARKER, 8'h00, 1'b1));
    end else begin
      ph = PH_DATA;
    end
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    logic [7:0] kb;
    case (ph)
      PH_LEN: begin
        masked = b[7];
        if (!b[7]) key = '0;
        hdr_idx = '0;
        bytes_left = '0;
        if (b[6:0] == LEN7_EXT16) begin
          ph = PH_EXT16;
        end else if (b[6:0] == LEN7_EXT64) begin
          ph = PH_EXT64;
        end else begin
          bytes_left = {25'd0, b[6:0]};
          finish_header(1'b0);
        end
      end
      PH_EXT16, PH_EXT64: begin
        bytes_left = {bytes_left[23:0], b};
        if (hdr_idx == ((ph == PH_EXT16) ? EXT16_LAST : EXT64_LAST)) finish_header(1'b0);
        else hdr_idx = hdr_idx + 3'd1;
      end
      PH_KEY: begin
        key[8*hdr_idx +: 8] = b;
        if (hdr_idx == KEY_LAST) finish_header(1'b1);
        else hdr_idx = hdr_idx + 3'd1;
      end
      PH_DATA: begin
        kb = masked ? key[8*key_pos +: 8] : 8'h00;
        key_pos = key_pos + 2'd1;
        bytes_left = bytes_left - 32'd1;
        if (bytes_left == 0) begin
          ph = PH_FLAG;
          predicted_beats.push_back(make_beat(KIND_DATA, b ^ kb, 1'b1));
        end else begin
          predicted_beats.push_back(make_beat(KIND_DATA, b ^ kb, 1'b0));
        end
      end
      default: begin
        op = b[3:0];
        fin_bit = b[7];
        hdr_idx = '0;
        ph = PH_LEN;
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ph = PH_FLAG;
      hdr_idx = '0;
      bytes_left = '0;
      key = '0;
      masked = 1'b0;
      key_pos = '0;
      op = '0;
      fin_bit = 1'b0;
      fail_count = 0;
      predicted_beats.delete();
    end else begin
      if (in_valid && in_ready) parse_rx_byte(in_rx_byte);
      if (out_valid && out_ready) begin
        got.kind          = kind_t'(out_kind);
        got.payload_byte  = out_payload_byte;
        got.frame_opcode  = out_frame_opcode;
        got.is_control    = out_is_control;
        got.message_first = out_message_first;
        got.final_frame   = out_final_frame;
        got.frame_last    = out_frame_last;
        if (predicted_beats.size() == 0) begin
          fail_count = fail_count + 1;
          if (fail_count <= 10)
            $display("unexpected beat: kind=%0d byte=%02h op=%0h ctl=%0d first=%0d fin=%0d last=%0d",
                     got.kind, got.payload_byte, got.frame_opcode, got.is_control,
                     got.message_first, got.final_frame, got.frame_last);
        end else begin
          want = predicted_beats.pop_front();
          if (got !== want) begin
            fail_count = fail_count + 1;
            if (fail_count <= 10) begin
              $display("mismatch expected: kind=%0d byte=%02h op=%0h ctl=%0d first=%0d fin=%0d last=%0d",
                       want.kind, want.payload_byte, want.frame_opcode, want.is_control,
                       want.message_first, want.final_frame, want.frame_last);
              $display("         actual:   kind=%0d byte=%02h op=%0h ctl=%0d first=%0d fin=%0d last=%0d",
                       got.kind, got.payload_byte, got.frame_opcode, got.is_control,
                       got.message_first, got.final_frame, got.frame_last);
            end
          end
        end
      end
    end
    pending = predicted_beats.size();
  end

endmodule

>>> tb/tb_websocket_frame_deframer.sv
// top of the websocket frame deframer testbench: clock, reset, frame stimulus and verdict
// depends on wsd_pkg, websocket_frame_deframer and wsd_frame_checker
`timescale 1ns / 1ps

module tb_websocket_frame_deframer;
  import wsd_pkg::*;

  localparam int CYCLE_LIMIT = 300000;

  typedef enum int {
    LEN_SHORT,
    LEN_EXT16,
    LEN_EXT64
  } len_form_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic       out_kind;
  logic [7:0] out_payload_byte;
  logic [3:0] out_frame_opcode;
  logic       out_is_control;
  logic       out_message_first;
  logic       out_final_frame;
  logic       out_frame_last;

  int fail_count;
  int pending;
  int cycle_cnt = 0;
  int bytes_sent = 0;
  int stall_left = 0;
  bit in_burst = 0;
  bit out_burst = 0;
  logic out_fire = 1'b0;

  websocket_frame_deframer u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_payload_byte  (out_payload_byte),
    .out_frame_opcode  (out_frame_opcode),
    .out_is_control    (out_is_control),
    .out_message_first (out_message_first),
    .out_final_frame   (out_final_frame),
    .out_frame_last    (out_frame_last)
  );

  wsd_frame_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_payload_byte  (out_payload_byte),
    .out_frame_opcode  (out_frame_opcode),
    .out_is_control    (out_is_control),
    .out_message_first (out_message_first),
    .out_final_frame   (out_final_frame),
    .out_frame_last    (out_frame_last),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver stalls drawn per result beat
  always @(posedge clk) out_fire <= out_valid && out_ready;

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fire) stall_left = out_burst ? 0 : $urandom_range(0, 11);
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end else begin
      out_ready <= 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent = bytes_sent + 1;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] flag, input len_form_t form,
                            input logic [31:0] len, input logic [31:0] len_hi,
                            input bit masked, input logic [31:0] key, input int unsigned cap);
    int unsigned n;
    send_byte(flag);
    case (form)
      LEN_SHORT: begin
        send_byte({masked, len[6:0]});
      end
      LEN_EXT16: begin
        send_byte({masked, LEN7_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({masked, LEN7_EXT64});
        for (int i = 3; i >= 0; i--) send_byte(len_hi[8*i +: 8]);
        for (int i = 3; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
    if (masked)
      for (int i = 0; i < 4; i++) send_byte(key[8*i +: 8]);
    n = (cap < len) ? cap : len;
    repeat (n) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    logic [7:0] flag;
    logic [31:0] len;
    len_form_t form;
    int unsigned pick;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty text frame, empty masked pong with reserved bits, masked ping,
    // extended 16-bit continuation, 64-bit length that wraps to empty
    send_frame(8'h81, LEN_SHORT, 32'd0, 32'd0, 1'b0, 32'h0, 0);
    send_frame(8'h7a, LEN_SHORT, 32'd0, 32'd0, 1'b1, 32'hffff_ffff, 0);
    send_frame(8'h89, LEN_SHORT, 32'd1, 32'd0, 1'b1, 32'h5aa5_00ff, 1);
    send_frame(8'h00, LEN_EXT16, 32'd1, 32'd0, 1'b0, 32'h0, 1);
    send_frame(8'h8f, LEN_EXT64, 32'd0, 32'hffff_ffff, 1'b0, 32'h0, 0);
    drain_results();

    while (bytes_sent < 900) begin
      in_burst = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      flag = 8'($urandom);
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        form = LEN_SHORT;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 12);
      end else if (pick < 8) begin
        form = LEN_EXT16;
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 30);
      end else begin
        form = LEN_EXT64;
        len = $urandom_range(0, 20);
      end
      send_frame(flag, form, len, $urandom, 1'($urandom_range(0, 1)), $urandom, len);
      if ($urandom_range(0, 15) == 0) drain_results();
    end

    // frame far longer than the run, left open at the end
    send_frame(8'h82, LEN_EXT16, 32'h0000_ffff, 32'd0, 1'b1, $urandom, 24);
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
